// ----- rtl/pn_pkg.sv -----
package pn_pkg;

  // Shortest normalized path, in characters, that is rejected.
  localparam int unsigned PATH_MAX = 256;

  // Output character count: holds PATH_MAX plus the largest burst of four.
  localparam int unsigned CNT_W = $clog2(PATH_MAX + 4);

  // Depth of the queue between classifier and emitter.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result status codes.
  localparam logic [1:0] ST_CHAR = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Character constants.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LO    = 8'd32;
  localparam logic [7:0] CH_HI    = 8'd126;

  // One burst of results, as classified by the front end.
  typedef struct packed {
    logic       is_status;
    logic [1:0] status;
    logic       sep;
    logic [1:0] dots;
    logic [7:0] ch;
  } burst_t;

endpackage

// ----- rtl/pn_front.sv -----
module pn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             q_ready_i,
  output logic             push_o,
  output pn_pkg::burst_t   burst_o
);

  localparam logic [2:0] PH_AWAIT    = 3'd0;
  localparam logic [2:0] PH_BOUNDARY = 3'd1;
  localparam logic [2:0] PH_DOTS     = 3'd2;
  localparam logic [2:0] PH_SEG      = 3'd3;
  localparam logic [2:0] PH_FAULT    = 3'd4;

  logic [2:0]               phase_q, phase_d;
  logic [1:0]               dots_q, dots_d;
  logic [pn_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic                     accept;
  logic                     printable;
  logic                     seg_sep;
  logic [1:0]               seg_dots;
  logic [pn_pkg::CNT_W-1:0] need;
  logic                     seg_ovf;
  logic                     char_ovf;
  logic                     push;
  pn_pkg::burst_t           burst;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign printable  = (in_byte_i >= pn_pkg::CH_LO) && (in_byte_i <= pn_pkg::CH_HI);

  // Cost of opening a new segment: separator, held dots and the character.
  assign seg_sep  = cnt_q > pn_pkg::CNT_W'(1);
  assign seg_dots = (phase_q == PH_DOTS) ? dots_q : 2'd0;
  assign need     = pn_pkg::CNT_W'(seg_sep) + pn_pkg::CNT_W'(seg_dots) + pn_pkg::CNT_W'(1);
  assign seg_ovf  = (cnt_q + need) >= pn_pkg::CNT_W'(pn_pkg::PATH_MAX);
  assign char_ovf = (cnt_q + pn_pkg::CNT_W'(1)) >= pn_pkg::CNT_W'(pn_pkg::PATH_MAX);

  always_comb begin
    phase_d         = phase_q;
    dots_d          = dots_q;
    cnt_d           = cnt_q;
    push            = 1'b0;
    burst.is_status = 1'b0;
    burst.status    = pn_pkg::ST_CHAR;
    burst.sep       = seg_sep;
    burst.dots      = seg_dots;
    burst.ch        = in_byte_i;

    unique case (phase_q)
      PH_AWAIT: begin
        if (in_byte_i == pn_pkg::CH_NUL) begin
          push            = 1'b1;
          burst.is_status = 1'b1;
          burst.status    = pn_pkg::ST_ERR;
        end else if (in_byte_i != pn_pkg::CH_SLASH) begin
          phase_d = PH_FAULT;
        end else begin
          push      = 1'b1;
          burst.sep = 1'b0;
          burst.dots = 2'd0;
          cnt_d     = pn_pkg::CNT_W'(1);
          phase_d   = PH_BOUNDARY;
        end
      end
      PH_BOUNDARY, PH_DOTS, PH_SEG: begin
        priority if (in_byte_i == pn_pkg::CH_NUL) begin
          push            = 1'b1;
          burst.is_status = 1'b1;
          burst.status    = (phase_q == PH_DOTS && dots_q >= 2'd2) ?
                            pn_pkg::ST_ERR : pn_pkg::ST_OK;
          phase_d         = PH_AWAIT;
          dots_d          = 2'd0;
          cnt_d           = '0;
        end else if (in_byte_i == pn_pkg::CH_SLASH) begin
          phase_d = (phase_q == PH_DOTS && dots_q >= 2'd2) ? PH_FAULT : PH_BOUNDARY;
          dots_d  = 2'd0;
        end else if (!printable) begin
          phase_d = PH_FAULT;
          dots_d  = 2'd0;
        end else if (phase_q == PH_SEG) begin
          if (char_ovf) begin
            phase_d = PH_FAULT;
          end else begin
            push       = 1'b1;
            burst.sep  = 1'b0;
            burst.dots = 2'd0;
            cnt_d      = cnt_q + pn_pkg::CNT_W'(1);
          end
        end else if (in_byte_i == pn_pkg::CH_DOT && phase_q == PH_BOUNDARY) begin
          dots_d  = 2'd1;
          phase_d = PH_DOTS;
        end else if (in_byte_i == pn_pkg::CH_DOT && dots_q < 2'd2) begin
          dots_d = dots_q + 2'd1;
        end else if (seg_ovf) begin
          phase_d = PH_FAULT;
          dots_d  = 2'd0;
        end else begin
          push    = 1'b1;
          cnt_d   = cnt_q + need;
          dots_d  = 2'd0;
          phase_d = PH_SEG;
        end
      end
      default: begin
        if (in_byte_i == pn_pkg::CH_NUL) begin
          push            = 1'b1;
          burst.is_status = 1'b1;
          burst.status    = pn_pkg::ST_ERR;
          phase_d         = PH_AWAIT;
          dots_d          = 2'd0;
          cnt_d           = '0;
        end
      end
    endcase

    if (burst.is_status) begin
      burst.sep  = 1'b0;
      burst.dots = 2'd0;
      burst.ch   = pn_pkg::CH_NUL;
    end
  end

  assign push_o  = accept & push;
  assign burst_o = burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AWAIT;
      dots_q  <= 2'd0;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      dots_q  <= dots_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/pn_queue.sv -----
module pn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pn_pkg::burst_t push_data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pn_pkg::burst_t pop_data_o
);

  pn_pkg::burst_t mem_q [pn_pkg::Q_DEPTH];

  logic [pn_pkg::Q_PTR_W-1:0] wr_q, rd_q;
  logic [pn_pkg::Q_CNT_W-1:0] cnt_q;
  logic                       do_push, do_pop;

  assign ready_o    = cnt_q != pn_pkg::Q_CNT_W'(pn_pkg::Q_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i & ready_o;
  assign do_pop     = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + pn_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + pn_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + pn_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - pn_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/pn_back.sv -----
module pn_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  pn_pkg::burst_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic [1:0]     status_o,
  output logic           last_o
);

  pn_pkg::burst_t cur_q;
  logic           cur_valid_q;
  logic           out_valid_q;
  logic [7:0]     byte_q;
  logic [1:0]     status_q;
  logic           last_q;

  logic           can_load, emit, burst_end, cur_free, pop;
  logic [7:0]     byte_d;

  assign can_load  = !out_valid_q || out_ready_i;
  assign emit      = cur_valid_q & can_load;
  assign burst_end = cur_q.is_status || (!cur_q.sep && cur_q.dots == 2'd0);
  assign cur_free  = !cur_valid_q || (emit && burst_end);
  assign pop       = cur_free & q_valid_i;
  assign q_pop_o   = pop;

  // Burst order: separator, then held dots, then the segment character.
  always_comb begin
    priority if (cur_q.is_status) begin
      byte_d = pn_pkg::CH_NUL;
    end else if (cur_q.sep) begin
      byte_d = pn_pkg::CH_SLASH;
    end else if (cur_q.dots != 2'd0) begin
      byte_d = pn_pkg::CH_DOT;
    end else begin
      byte_d = cur_q.ch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_q <= 1'b1;
      end else if (cur_free) begin
        cur_valid_q <= 1'b0;
      end
      if (can_load) begin
        out_valid_q <= cur_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_data_i;
    end else if (emit) begin
      if (cur_q.sep) begin
        cur_q.sep <= 1'b0;
      end else if (cur_q.dots != 2'd0) begin
        cur_q.dots <= cur_q.dots - 2'd1;
      end
    end
    if (emit) begin
      byte_q   <= byte_d;
      status_q <= cur_q.is_status ? cur_q.status : pn_pkg::ST_CHAR;
      last_q   <= cur_q.is_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/path_normalizer_top.sv -----
// Path: bursts pass the queue and cur_q; each result is registered at the output.
// Throughput: one input byte per cycle; results leave the emitter at one per cycle
// while taken downstream, so a burst of up to four results holds the input only once the
// four-entry queue between classifier and emitter has filled.
// Reset: rst_ni is asynchronous and active low; it clears the path state, the queue
// and the output register, and the block accepts bytes in the first cycle after it.
module path_normalizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  // The front end classifies each byte against the running path state and
  // turns it into at most one burst descriptor: either a status result that
  // ends the path, or a run of characters made of an optional separator,
  // up to two held dots and the byte itself. Bytes that produce nothing
  // (extra slashes, held dots, bytes swallowed after a fault) push nothing.
  logic           push;
  logic           q_ready;
  pn_pkg::burst_t push_burst;

  // The back end expands one descriptor into results, one per cycle while the
  // downstream side takes them, into an output register that it refills in the
  // same cycle in which the downstream transfer takes place.
  logic           q_valid;
  logic           q_pop;
  pn_pkg::burst_t pop_burst;

  pn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .burst_o    (push_burst)
  );

  // The queue decouples the two halves, so that a stalled consumer does not
  // stop the classifier until several bursts are waiting.
  pn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_burst),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_burst)
  );

  pn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_burst),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
